// ----- rtl/bcdasc_pkg.sv -----
// Package for the BCD add/subtract/compare block.
// Holds digit constants and the per-lane result struct; no dependencies.
package bcdasc_pkg;

  localparam int NIBBLES   = 16;
  localparam int DIGITS    = 16;
  localparam int WORD_W    = 4 * NIBBLES;
  localparam logic [4:0] DIGIT_MAX = 5'd9;
  localparam logic [4:0] RADIX     = 5'd10;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_t;

  // One digit lane: result digit for carry/borrow in of 0 and 1,
  // generate/propagate of the carry chain, compare and check bits.
  typedef struct packed {
    logic [3:0] dig_c0;
    logic [3:0] dig_c1;
    logic       gen;
    logic       prop;
    logic       lt;
    logic       gt;
    logic       nz;
    logic       bad;
  } lane_t;

endpackage

// ----- rtl/bcdasc_lane.sv -----
// One decimal digit lane: forms both carry-in variants of the digit and
// the lane's carry, compare and check bits, then registers them. Uses bcdasc_pkg.
module bcdasc_lane
  import bcdasc_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic       kind,
  input  logic [3:0] a_nib,
  input  logic [3:0] b_nib,
  output lane_t      lane_r
);

  lane_t      lane_nxt;
  logic [4:0] da;
  logic [4:0] db;
  logic [4:0] sum0;
  logic [4:0] sum1;
  logic [4:0] take1;
  logic [4:0] dif0;
  logic [4:0] dif1;
  logic       a_bad;
  logic       b_bad;

  always_comb begin
    a_bad = ({1'b0, a_nib} > DIGIT_MAX);
    b_bad = ({1'b0, b_nib} > DIGIT_MAX);
    da    = a_bad ? 5'd0 : {1'b0, a_nib};
    db    = b_bad ? 5'd0 : {1'b0, b_nib};
    sum0  = da + db;
    sum1  = sum0 + 5'd1;
    take1 = db + 5'd1;
    dif0  = (da >= db)    ? (da - db)    : (da + RADIX - db);
    dif1  = (da >= take1) ? (da - take1) : (da + RADIX - take1);

    lane_nxt.lt  = (da < db);
    lane_nxt.gt  = (da > db);
    lane_nxt.nz  = (da != 5'd0);
    lane_nxt.bad = a_bad | b_bad;

    unique case (op_t'(kind))
      OP_ADD: begin
        lane_nxt.gen    = (sum0 > DIGIT_MAX);
        lane_nxt.prop   = (sum0 == DIGIT_MAX);
        lane_nxt.dig_c0 = (sum0 > DIGIT_MAX) ? 4'(sum0 - RADIX) : sum0[3:0];
        lane_nxt.dig_c1 = (sum1 > DIGIT_MAX) ? 4'(sum1 - RADIX) : sum1[3:0];
      end
      OP_SUB: begin
        lane_nxt.gen    = (da < db);
        lane_nxt.prop   = (da == db);
        lane_nxt.dig_c0 = dif0[3:0];
        lane_nxt.dig_c1 = dif1[3:0];
      end
      default: begin
        lane_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

// ----- rtl/bcdasc_merge.sv -----
// Merge stage: resolves the carry/borrow chain across all lanes with one
// binary add, picks each digit, derives compare/zero/check flags, registers. Uses bcdasc_pkg.
module bcdasc_merge
  import bcdasc_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  lane_t             lanes [DIGITS],
  output logic [WORD_W-1:0] result_digits_r,
  output logic              carry_out_r,
  output logic              a_less_r,
  output logic              a_equal_r,
  output logic              a_greater_r,
  output logic              a_is_zero_r,
  output logic              invalid_digit_r
);

  logic [DIGITS-1:0] gen_v;
  logic [DIGITS-1:0] alive_v;
  logic [DIGITS-1:0] lt_v;
  logic [DIGITS-1:0] gt_v;
  logic [DIGITS-1:0] nz_v;
  logic [DIGITS-1:0] bad_v;
  logic [DIGITS-1:0] cin_v;
  logic [DIGITS:0]   chain;

  logic [WORD_W-1:0] result_digits_nxt;
  logic              carry_out_nxt;
  logic              a_less_nxt;
  logic              a_equal_nxt;
  logic              a_greater_nxt;
  logic              a_is_zero_nxt;
  logic              invalid_digit_nxt;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      gen_v[i]   = lanes[i].gen;
      alive_v[i] = lanes[i].gen | lanes[i].prop;
      lt_v[i]    = lanes[i].lt;
      gt_v[i]    = lanes[i].gt;
      nz_v[i]    = lanes[i].nz;
      bad_v[i]   = lanes[i].bad;
    end
    // carry into digit i is the carry bit of gen + alive at position i
    chain = {1'b0, gen_v} + {1'b0, alive_v};
    cin_v = chain[DIGITS-1:0] ^ gen_v ^ alive_v;

    result_digits_nxt = '0;
    for (int i = 0; i < DIGITS; i++) begin
      result_digits_nxt[4*i +: 4] = cin_v[i] ? lanes[i].dig_c1 : lanes[i].dig_c0;
    end
    carry_out_nxt = chain[DIGITS];

    // highest differing digit wins: compare the lt/gt masks as integers
    a_less_nxt        = (lt_v > gt_v);
    a_greater_nxt     = (gt_v > lt_v);
    a_equal_nxt       = ~(|lt_v) & ~(|gt_v);
    a_is_zero_nxt     = ~(|nz_v);
    invalid_digit_nxt = |bad_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_digits_r <= result_digits_nxt;
      carry_out_r     <= carry_out_nxt;
      a_less_r        <= a_less_nxt;
      a_equal_r       <= a_equal_nxt;
      a_greater_r     <= a_greater_nxt;
      a_is_zero_r     <= a_is_zero_nxt;
      invalid_digit_r <= invalid_digit_nxt;
    end
  end

endmodule

// ----- rtl/bcd_add_sub_compare_top.sv -----
// Top level of the BCD add/subtract/compare block.
// Instantiates the digit lanes (bcdasc_lane) and the merge stage (bcdasc_merge); uses bcdasc_pkg.
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_ready   in_kind, in_operand_a, in_operand_b
//   out_     out  out_valid / out_ready out_result_digits, out_carry_out, out_a_less,
//                                       out_a_equal, out_a_greater, out_a_is_zero,
//                                       out_invalid_digit
//
// Two register stages: lane registers, then the merge/output register.
// One request per cycle unless both stages are full and out_ready is low; each request is
// registered in the lane registers, then in the merge/output register, which holds it until taken.
// Each stage holds while the stage after it is full and stalled; in_ready
// drops only when both stages are full and out_ready is low.
// Synchronous active-low reset clears the stage valid bits only.
module bcd_add_sub_compare_top
  import bcdasc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [WORD_W-1:0] in_operand_a,
  input  logic [WORD_W-1:0] in_operand_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_result_digits,
  output logic              out_carry_out,
  output logic              out_a_less,
  output logic              out_a_equal,
  output logic              out_a_greater,
  output logic              out_a_is_zero,
  output logic              out_invalid_digit
);

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  logic  s2_valid_r;
  logic  s2_valid_nxt;
  logic  s2_ready;
  logic  s1_ready;
  logic  s1_en;
  logic  s2_en;
  lane_t lanes [DIGITS];

  always_comb begin
    s2_ready     = ~s2_valid_r | out_ready;
    s1_ready     = ~s1_valid_r | s2_ready;
    s1_en        = s1_ready;
    s2_en        = s2_ready;
    s1_valid_nxt = s1_ready ? in_valid : s1_valid_r;
    s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;
  end

  assign in_ready  = s1_ready;
  assign out_valid = s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  for (genvar g = 0; g < DIGITS; g++) begin : g_lane
    bcdasc_lane u_lane (
      .clk    (clk),
      .en     (s1_en),
      .kind   (in_kind),
      .a_nib  (in_operand_a[4*g +: 4]),
      .b_nib  (in_operand_b[4*g +: 4]),
      .lane_r (lanes[g])
    );
  end

  bcdasc_merge u_merge (
    .clk             (clk),
    .en              (s2_en),
    .lanes           (lanes),
    .result_digits_r (out_result_digits),
    .carry_out_r     (out_carry_out),
    .a_less_r        (out_a_less),
    .a_equal_r       (out_a_equal),
    .a_greater_r     (out_a_greater),
    .a_is_zero_r     (out_a_is_zero),
    .invalid_digit_r (out_invalid_digit)
  );

endmodule
